[rtl/hpva_pkg.sv]
// Shared types, codes, widths and coefficient math for the Hough plane vote accumulator.
package hpva_pkg;

    // Default bin counts
    localparam int THETA_BINS_DEF = 32;
    localparam int PHI_BINS_DEF   = 16;
    localparam int RHO_BINS_DEF   = 64;

    // Pi in Q30, used to build the angle tables
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Request opcodes
    localparam logic [1:0] OP_VOTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_RHO_LIMIT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RHO_SCALE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VOTE_THRESHOLD = 2'd2;

    // Register widths and reset values
    localparam int RHO_LIMIT_W = 23;
    localparam int RHO_SCALE_W = 24;
    localparam int COUNT_W     = 16;
    localparam logic [RHO_SCALE_W-1:0] RHO_SCALE_RST = 24'd65536;
    localparam logic [COUNT_W-1:0]     COUNT_MAX     = 16'hFFFF;

    // Datapath widths of the shared multiplier and the rho sums
    localparam int COEF_W = 16;
    localparam int MA_W   = 42;
    localparam int MB_W   = 25;
    localparam int MP_W   = MA_W + MB_W;
    localparam int SUM_W  = 41;
    localparam int U_W    = 58;
    localparam int FRAC_SHIFT = 30;
    localparam int BIN_SHIFT  = 24;
    localparam int Z_SHIFT    = 15;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic [4:0]         theta_sel;
        logic [3:0]         phi_sel;
        logic [5:0]         rho_sel;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] vote_count;
        logic               is_plane;
        logic               clamped;
    } res_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_th;
        logic signed [COEF_W-1:0] sin_th;
        logic signed [COEF_W-1:0] cos_phi;
        logic signed [COEF_W-1:0] sin_phi;
    } coef_t;

    // Sine of a Q30 angle in [0, pi/2], rounded to Q1.15 (degree 15 Taylor series)
    function automatic logic signed [COEF_W-1:0] sin_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        logic signed [63:0] r;
        x2  = (x * x) >> 30;
        t   = x;
        acc = signed'(x);
        t   = ((t * x2) >> 30) / 64'd6;
        acc = acc - signed'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + signed'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - signed'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + signed'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - signed'(t);
        t   = ((t * x2) >> 30) / 64'd156;
        acc = acc + signed'(t);
        t   = ((t * x2) >> 30) / 64'd210;
        acc = acc - signed'(t);
        if (acc < 64'sd0)
        begin
            acc = 64'sd0;
        end
        r = (acc + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
        begin
            r = 64'sd32767;
        end
        return COEF_W'(r);
    endfunction

endpackage

[rtl/hpva_coef.sv]
// Constant sine/cosine tables for the theta and phi bins, looked up by bin index.
module hpva_coef #(
    parameter int THETA_BINS = hpva_pkg::THETA_BINS_DEF,
    parameter int PHI_BINS   = hpva_pkg::PHI_BINS_DEF
) (
    input  logic [$clog2(THETA_BINS)-1:0] theta_idx,
    input  logic [$clog2(PHI_BINS)-1:0]   phi_idx,
    output hpva_pkg::coef_t               coef
);

    localparam int PHI_D = 2 * (PHI_BINS - 1);

    logic signed [hpva_pkg::COEF_W-1:0] ct_rom [THETA_BINS];
    logic signed [hpva_pkg::COEF_W-1:0] st_rom [THETA_BINS];
    logic signed [hpva_pkg::COEF_W-1:0] cp_rom [PHI_BINS];
    logic signed [hpva_pkg::COEF_W-1:0] sp_rom [PHI_BINS];

    // Build theta entries: angle i*pi/THETA_BINS
    for (genvar gi = 0; gi < THETA_BINS; gi++)
    begin : g_theta
        localparam bit SFOLD = (2 * gi > THETA_BINS);
        localparam int SN    = SFOLD ? THETA_BINS - gi : gi;
        localparam logic [63:0] SX =
            (hpva_pkg::PI_Q30 * 64'(SN)) / 64'(THETA_BINS);
        localparam bit CNEG  = (2 * gi > THETA_BINS);
        localparam int CN    = CNEG ? 2 * gi - THETA_BINS : THETA_BINS - 2 * gi;
        localparam logic [63:0] CX =
            (hpva_pkg::PI_Q30 * 64'(CN)) / 64'(2 * THETA_BINS);
        localparam logic signed [hpva_pkg::COEF_W-1:0] SV = hpva_pkg::sin_q15(SX);
        localparam logic signed [hpva_pkg::COEF_W-1:0] CV =
            CNEG ? -hpva_pkg::sin_q15(CX) : hpva_pkg::sin_q15(CX);
        assign st_rom[gi] = SV;
        assign ct_rom[gi] = CV;
    end

    // Build phi entries: angle j*pi/(2*(PHI_BINS-1))
    for (genvar gj = 0; gj < PHI_BINS; gj++)
    begin : g_phi
        localparam bit SFOLD = (2 * gj > PHI_D);
        localparam int SN    = SFOLD ? PHI_D - gj : gj;
        localparam logic [63:0] SX =
            (hpva_pkg::PI_Q30 * 64'(SN)) / 64'(PHI_D);
        localparam bit CNEG  = (2 * gj > PHI_D);
        localparam int CN    = CNEG ? 2 * gj - PHI_D : PHI_D - 2 * gj;
        localparam logic [63:0] CX =
            (hpva_pkg::PI_Q30 * 64'(CN)) / 64'(2 * PHI_D);
        localparam logic signed [hpva_pkg::COEF_W-1:0] SV = hpva_pkg::sin_q15(SX);
        localparam logic signed [hpva_pkg::COEF_W-1:0] CV =
            CNEG ? -hpva_pkg::sin_q15(CX) : hpva_pkg::sin_q15(CX);
        assign sp_rom[gj] = SV;
        assign cp_rom[gj] = CV;
    end

    // Look up the current bin pair
    assign coef.cos_th  = ct_rom[theta_idx];
    assign coef.sin_th  = st_rom[theta_idx];
    assign coef.cos_phi = cp_rom[phi_idx];
    assign coef.sin_phi = sp_rom[phi_idx];

endmodule

[rtl/hough_plane_vote_accumulator_top.sv]
// Top level of the Hough plane vote accumulator: sequencer, shared multiplier and vote store.
//
// One request at a time, accepted when start is high and busy is low; each request
// gives exactly one result, shown for one cycle with done high. In a vote a single
// multiplier is reused for every product: per theta bin the states XMUL, YMUL and
// ASUM form x*cos+y*sin, and each theta-phi cell then steps through CMUL, ZMUL, CSUM,
// BMUL, ADDR and WRITE (two products for rho, one for binning and a read-modify-write
// of the store). A read goes through the store's registered read port; a read outside
// the bin ranges or an unused opcode answers from idle without a store access. A
// clear sweeps the store one cell a cycle over all THETA_BINS*PHI_BINS*RHO_BINS cells,
// and the same sweep runs after reset, with busy high and no result. Configuration
// writes are taken at any time and must only be issued while the block is idle.
module hough_plane_vote_accumulator_top #(
    parameter int THETA_BINS = hpva_pkg::THETA_BINS_DEF,
    parameter int PHI_BINS   = hpva_pkg::PHI_BINS_DEF,
    parameter int RHO_BINS   = hpva_pkg::RHO_BINS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hpva_pkg::cmd_t                      cmd,
    output logic                                done,
    output hpva_pkg::res_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hpva_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hpva_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CELLS = THETA_BINS * PHI_BINS * RHO_BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int TW    = $clog2(THETA_BINS);
    localparam int PW    = $clog2(PHI_BINS);
    localparam int KW    = $clog2(RHO_BINS);
    localparam int BRW   = hpva_pkg::MP_W - hpva_pkg::BIN_SHIFT;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_XMUL  = 4'd3;
    localparam logic [3:0] ST_YMUL  = 4'd4;
    localparam logic [3:0] ST_ASUM  = 4'd5;
    localparam logic [3:0] ST_CMUL  = 4'd6;
    localparam logic [3:0] ST_ZMUL  = 4'd7;
    localparam logic [3:0] ST_CSUM  = 4'd8;
    localparam logic [3:0] ST_BMUL  = 4'd9;
    localparam logic [3:0] ST_ADDR  = 4'd10;
    localparam logic [3:0] ST_WRITE = 4'd11;

    logic [3:0]                          state_reg, state_next;
    logic [TW-1:0]                       i_reg, i_next;
    logic [PW-1:0]                       j_reg, j_next;
    logic [AW-1:0]                       clr_cnt_reg, clr_cnt_next;
    logic                                clr_op_reg, clr_op_next;
    logic                                clamp_reg, clamp_next;
    logic                                done_reg, done_next;
    hpva_pkg::res_t                      res_reg, res_next;
    hpva_pkg::cmd_t                      pt_reg, pt_next;
    logic signed [hpva_pkg::SUM_W-1:0]   a_reg, a_next;
    logic signed [hpva_pkg::U_W-1:0]     u_reg, u_next;
    logic signed [hpva_pkg::MP_W-1:0]    p_reg;
    logic [AW-1:0]                       wr_addr_reg, wr_addr_next;

    logic [hpva_pkg::RHO_LIMIT_W-1:0]    rho_limit_reg;
    logic [hpva_pkg::RHO_SCALE_W-1:0]    rho_scale_reg;
    logic [hpva_pkg::COUNT_W-1:0]        vote_threshold_reg;

    logic [hpva_pkg::COUNT_W-1:0]        mem [CELLS];
    logic [hpva_pkg::COUNT_W-1:0]        rd_data_reg;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [AW-1:0]                       mem_raddr;
    logic [hpva_pkg::COUNT_W-1:0]        mem_wdata;

    hpva_pkg::coef_t                     coef;
    logic signed [hpva_pkg::MA_W-1:0]    mul_a;
    logic signed [hpva_pkg::MB_W-1:0]    mul_b;
    logic signed [hpva_pkg::MP_W-1:0]    prod;
    logic signed [hpva_pkg::U_W-1:0]     rho_off;
    logic [BRW-1:0]                      bin_raw;
    logic                                bin_clamp;
    logic [KW-1:0]                       bin;
    logic [AW-1:0]                       cell_addr;
    logic                                sel_in_range;
    logic [AW-1:0]                       sel_addr;
    logic [hpva_pkg::COUNT_W-1:0]        inc_count;

    hpva_coef #(
        .THETA_BINS(THETA_BINS),
        .PHI_BINS  (PHI_BINS)
    ) u_coef (
        .theta_idx(i_reg),
        .phi_idx  (j_reg),
        .coef     (coef)
    );

    // Select operands for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_YMUL:
            begin
                mul_a = hpva_pkg::MA_W'(pt_reg.py);
                mul_b = hpva_pkg::MB_W'(coef.sin_th);
            end
            ST_CMUL:
            begin
                mul_a = hpva_pkg::MA_W'(a_reg);
                mul_b = hpva_pkg::MB_W'(coef.sin_phi);
            end
            ST_ZMUL:
            begin
                mul_a = hpva_pkg::MA_W'(pt_reg.pz);
                mul_b = hpva_pkg::MB_W'(coef.cos_phi);
            end
            ST_BMUL:
            begin
                mul_a = signed'(hpva_pkg::MA_W'(u_reg[hpva_pkg::U_W-1:hpva_pkg::FRAC_SHIFT]));
                mul_b = signed'(hpva_pkg::MB_W'(rho_scale_reg));
            end
            default:
            begin
                mul_a = hpva_pkg::MA_W'(pt_reg.px);
                mul_b = hpva_pkg::MB_W'(coef.cos_th);
            end
        endcase
    end

    assign prod = hpva_pkg::MP_W'(mul_a) * hpva_pkg::MP_W'(mul_b);

    // Offset rho_limit up to the Q30 scale of rho
    assign rho_off = signed'(hpva_pkg::U_W'(rho_limit_reg) << hpva_pkg::FRAC_SHIFT);

    // Bin the scaled rho and clamp to range
    assign bin_raw = p_reg[hpva_pkg::MP_W-1:hpva_pkg::BIN_SHIFT];

    always_comb
    begin
        if (u_reg[hpva_pkg::U_W-1])
        begin
            bin_clamp = 1'b1;
            bin       = '0;
        end
        else if (bin_raw >= BRW'(RHO_BINS))
        begin
            bin_clamp = 1'b1;
            bin       = KW'(RHO_BINS - 1);
        end
        else
        begin
            bin_clamp = 1'b0;
            bin       = bin_raw[KW-1:0];
        end
    end

    assign cell_addr = AW'((int'(i_reg) * PHI_BINS + int'(j_reg)) * RHO_BINS + int'(bin));

    // Decode the read selection
    assign sel_in_range = (int'(cmd.theta_sel) < THETA_BINS) &&
                          (int'(cmd.phi_sel) < PHI_BINS) &&
                          (int'(cmd.rho_sel) < RHO_BINS);
    assign sel_addr = AW'((int'(cmd.theta_sel) * PHI_BINS + int'(cmd.phi_sel)) * RHO_BINS
                          + int'(cmd.rho_sel));

    assign inc_count = (rd_data_reg == hpva_pkg::COUNT_MAX) ? rd_data_reg
                                                           : rd_data_reg + 1'b1;

    // Sequence requests through the shared unit and the store
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_op_next  = clr_op_reg;
        clamp_next   = clamp_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        pt_next      = pt_reg;
        a_next       = a_reg;
        u_next       = u_reg;
        wr_addr_next = wr_addr_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = inc_count;
        mem_raddr    = cell_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        hpva_pkg::OP_VOTE:
                        begin
                            pt_next    = cmd;
                            i_next     = '0;
                            j_next     = '0;
                            clamp_next = 1'b0;
                            state_next = ST_XMUL;
                        end
                        hpva_pkg::OP_READ:
                        begin
                            if (sel_in_range)
                            begin
                                mem_raddr  = sel_addr;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                            end
                        end
                        hpva_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_op_next  = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = '0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                    if (clr_op_reg)
                    begin
                        done_next = 1'b1;
                        res_next  = '0;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                done_next           = 1'b1;
                res_next.vote_count = rd_data_reg;
                res_next.is_plane   = (rd_data_reg > vote_threshold_reg);
                res_next.clamped    = 1'b0;
                state_next          = ST_IDLE;
            end
            ST_XMUL:
            begin
                state_next = ST_YMUL;
            end
            ST_YMUL:
            begin
                a_next     = hpva_pkg::SUM_W'(p_reg);
                state_next = ST_ASUM;
            end
            ST_ASUM:
            begin
                a_next     = a_reg + hpva_pkg::SUM_W'(p_reg);
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                state_next = ST_ZMUL;
            end
            ST_ZMUL:
            begin
                u_next     = hpva_pkg::U_W'(p_reg) + rho_off;
                state_next = ST_CSUM;
            end
            ST_CSUM:
            begin
                u_next     = u_reg + (hpva_pkg::U_W'(p_reg) <<< hpva_pkg::Z_SHIFT);
                state_next = ST_BMUL;
            end
            ST_BMUL:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                wr_addr_next = cell_addr;
                if (bin_clamp)
                begin
                    clamp_next = 1'b1;
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (j_reg == PW'(PHI_BINS - 1))
                begin
                    j_next = '0;
                    if (i_reg == TW'(THETA_BINS - 1))
                    begin
                        done_next           = 1'b1;
                        res_next.vote_count = '0;
                        res_next.is_plane   = 1'b0;
                        res_next.clamped    = clamp_reg;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_XMUL;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CMUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state; sweep the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            i_reg       <= '0;
            j_reg       <= '0;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            clamp_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            clamp_reg   <= clamp_next;
            done_reg    <= done_next;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        pt_reg      <= pt_next;
        a_reg       <= a_next;
        u_reg       <= u_next;
        p_reg       <= prod;
        wr_addr_reg <= wr_addr_next;
    end

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_limit_reg      <= '0;
            rho_scale_reg      <= hpva_pkg::RHO_SCALE_RST;
            vote_threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hpva_pkg::REG_RHO_LIMIT:
                begin
                    rho_limit_reg <= cfg_data[hpva_pkg::RHO_LIMIT_W-1:0];
                end
                hpva_pkg::REG_RHO_SCALE:
                begin
                    rho_scale_reg <= cfg_data[hpva_pkg::RHO_SCALE_W-1:0];
                end
                hpva_pkg::REG_VOTE_THRESHOLD:
                begin
                    vote_threshold_reg <= cfg_data[hpva_pkg::COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Vote store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // A vote request starts the theta loop on the next cycle
    a_vote_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == hpva_pkg::OP_VOTE) |=> (state_reg == ST_XMUL))
        else $error("vote request did not start the theta loop");

    // Only a finished vote reports clamping
    a_clamp_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.clamped) |-> ($past(state_reg) == ST_WRITE))
        else $error("clamped flag on a result that is not a vote");

    // Only a store read reports a plane
    a_plane_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.is_plane) |-> ($past(state_reg) == ST_READ))
        else $error("plane flag on a result that is not a read");

    // A vote increment never wraps a counter to zero
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (mem_wdata != '0))
        else $error("vote counter wrapped");

endmodule
